// ===== hdl/acs_pkg.sv =====
// Shared constants, types and helper functions of the ADC conversion sequencer.
package acs_pkg;

   // Slot and request queue geometry
   localparam int NUM_SLOTS   = 4;
   localparam int QUEUE_DEPTH = 8;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int SLOT_CNT_W  = 3;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Command queue between front and back
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PW     = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int CHAN_W      = 8;
   localparam int PERIOD_W    = 16;
   localparam int DROP_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CHAN_MAP_W  = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_CHANNEL_MAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_PERIOD_MAP  = 2'd2;

   // Command classes
   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_DONE = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [SAMPLE_W-1:0]   sample;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_POP  = 4'b0100,
      ST_NEXT = 4'b1000
   } seq_state_type;

   // Wrapping increment of a request queue pointer
   function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
      qptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

endpackage

// ===== hdl/acs_front.sv =====
// Front end: accepts input transfers, classifies them and queues commands.
module acs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [acs_pkg::SAMPLE_W-1:0]  req_sample_value,
   output logic                          cmd_valid,
   input  logic                          cmd_pop,
   output acs_pkg::cmd_type              cmd_data
);

   acs_pkg::cmd_type                    q_ff [acs_pkg::CMDQ_DEPTH];
   logic [acs_pkg::CMDQ_PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [acs_pkg::CMDQ_PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [acs_pkg::CMDQ_CW-1:0]         count_ff, count_in;
   acs_pkg::cmd_type                    new_cmd;
   logic                                push, pop;

   // Classify the incoming transfer
   always_comb begin
      new_cmd.kind   = req_func ? acs_pkg::CMD_DONE : acs_pkg::CMD_TICK;
      new_cmd.sample = req_sample_value;
   end

   assign req_ready = (count_ff != acs_pkg::CMDQ_CW'(acs_pkg::CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == acs_pkg::CMDQ_PW'(acs_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + acs_pkg::CMDQ_PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == acs_pkg::CMDQ_PW'(acs_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + acs_pkg::CMDQ_PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + acs_pkg::CMDQ_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - acs_pkg::CMDQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hdl/acs_back.sv =====
// Back end: slot countdowns, request queue and result register.
module acs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [acs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [acs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              cmd_valid,
   output logic                              cmd_pop,
   input  acs_pkg::cmd_type                  cmd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_start_valid,
   output logic [acs_pkg::CHAN_W-1:0]        rsp_start_channel,
   output logic                              rsp_result_valid,
   output logic [acs_pkg::SLOT_W-1:0]        rsp_result_slot,
   output logic [acs_pkg::SAMPLE_W-1:0]      rsp_result_value,
   output logic [acs_pkg::DROP_W-1:0]        rsp_dropped_requests,
   output logic                              rsp_spurious_done
);

   localparam int SW = acs_pkg::SLOT_W;
   localparam int QW = acs_pkg::QPTR_W;
   localparam int NS = acs_pkg::NUM_SLOTS;

   // Configuration registers
   logic [acs_pkg::SLOT_CNT_W-1:0]  slots_ff, slots_in;
   logic [acs_pkg::CHAN_MAP_W-1:0]  chan_map_ff, chan_map_in;
   logic [acs_pkg::CSR_DATA_W-1:0]  per_map_ff, per_map_in;

   // Slot and queue state
   logic [acs_pkg::PERIOD_W-1:0]    cd_ff [NS];
   logic [acs_pkg::PERIOD_W-1:0]    cd_in [NS];
   logic [QW-1:0]                   head_ff, head_in;
   logic [QW-1:0]                   tail_ff, tail_in;
   logic                            full_ff, full_in;
   logic [SW-1:0]                   mem [acs_pkg::QUEUE_DEPTH];
   logic [SW-1:0]                   rd_data_ff;
   logic [QW-1:0]                   rd_addr;
   logic                            mem_we;

   // Sequencer
   acs_pkg::seq_state_type          state_ff, state_in;
   logic [SW-1:0]                   slot_ff, slot_in;
   logic                            acc_start_ff, acc_start_in;
   logic [acs_pkg::CHAN_W-1:0]      acc_chan_ff, acc_chan_in;
   logic [acs_pkg::DROP_W-1:0]      acc_drop_ff, acc_drop_in;
   logic [acs_pkg::SAMPLE_W-1:0]    sample_ff, sample_in;

   // Result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_start_ff, rsp_start_in;
   logic [acs_pkg::CHAN_W-1:0]      rsp_chan_ff, rsp_chan_in;
   logic                            rsp_res_ff, rsp_res_in;
   logic [SW-1:0]                   rsp_slot_ff, rsp_slot_in;
   logic [acs_pkg::SAMPLE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [acs_pkg::DROP_W-1:0]      rsp_drop_ff, rsp_drop_in;
   logic                            rsp_spur_ff, rsp_spur_in;

   // Step values
   logic [acs_pkg::SLOT_CNT_W-1:0]  n_active, n_new;
   logic [acs_pkg::PERIOD_W-1:0]    cur_p, cur_c, dec;
   logic                            expire, q_empty, out_free, last_slot;
   logic [QW-1:0]                   head_nx, tail_nx;

   function automatic logic [acs_pkg::CHAN_W-1:0] channel_of(
      input logic [acs_pkg::CHAN_MAP_W-1:0] map,
      input logic [SW-1:0]                  s
   );
      channel_of = map[{s, 3'b000} +: acs_pkg::CHAN_W];
   endfunction

   // A period of zero behaves as one
   function automatic logic [acs_pkg::PERIOD_W-1:0] period_of(
      input logic [acs_pkg::CSR_DATA_W-1:0] map,
      input logic [SW-1:0]                  s
   );
      logic [acs_pkg::PERIOD_W-1:0] p;
      p = map[{s, 4'b0000} +: acs_pkg::PERIOD_W];
      period_of = (p == '0) ? acs_pkg::PERIOD_W'(1) : p;
   endfunction

   function automatic logic [acs_pkg::SLOT_CNT_W-1:0] clamp_slots(
      input logic [acs_pkg::SLOT_CNT_W-1:0] v
   );
      clamp_slots = (v > acs_pkg::SLOT_CNT_W'(NS)) ? acs_pkg::SLOT_CNT_W'(NS) : v;
   endfunction

   assign n_active  = clamp_slots(slots_ff);
   assign n_new     = clamp_slots(csr_wdata[acs_pkg::SLOT_CNT_W-1:0]);
   assign cur_p     = period_of(per_map_ff, slot_ff);
   assign cur_c     = (cd_ff[slot_ff] == '0) ? cur_p : cd_ff[slot_ff];
   assign dec       = cur_c - acs_pkg::PERIOD_W'(1);
   assign expire    = (dec == '0);
   assign q_empty   = !full_ff && (head_ff == tail_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_slot = (acs_pkg::SLOT_CNT_W'(slot_ff) ==
                       n_active - acs_pkg::SLOT_CNT_W'(1));
   assign head_nx   = acs_pkg::qptr_next(head_ff);
   assign tail_nx   = acs_pkg::qptr_next(tail_ff);

   // Sequencer next state
   always_comb begin
      slots_in     = slots_ff;
      chan_map_in  = chan_map_ff;
      per_map_in   = per_map_ff;
      cd_in        = cd_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      full_in      = full_ff;
      state_in     = state_ff;
      slot_in      = slot_ff;
      acc_start_in = acc_start_ff;
      acc_chan_in  = acc_chan_ff;
      acc_drop_in  = acc_drop_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_start_in = rsp_start_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_value_in = rsp_value_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_spur_in  = rsp_spur_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = head_ff;

      // Configuration writes; disabled slots lose their count
      if (csr_write_en) begin
         unique case (csr_index)
            acs_pkg::CSR_SLOTS_IN_USE: begin
               slots_in = csr_wdata[acs_pkg::SLOT_CNT_W-1:0];
               for (int i = 0; i < NS; i++) begin
                  if (acs_pkg::SLOT_CNT_W'(i) >= n_new) cd_in[i] = '0;
               end
            end
            acs_pkg::CSR_SLOT_CHANNEL_MAP: chan_map_in = csr_wdata[acs_pkg::CHAN_MAP_W-1:0];
            acs_pkg::CSR_SLOT_PERIOD_MAP:  per_map_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         acs_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop      = 1'b1;
               sample_in    = cmd_data.sample;
               acc_start_in = 1'b0;
               acc_chan_in  = '0;
               acc_drop_in  = '0;
               slot_in      = '0;
               if (cmd_data.kind == acs_pkg::CMD_TICK) begin
                  if (n_active == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_start_in = 1'b0;
                     rsp_chan_in  = '0;
                     rsp_res_in   = 1'b0;
                     rsp_slot_in  = '0;
                     rsp_value_in = '0;
                     rsp_drop_in  = '0;
                     rsp_spur_in  = 1'b0;
                  end else begin
                     state_in = acs_pkg::ST_SCAN;
                  end
               end else if (q_empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_start_in = 1'b0;
                  rsp_chan_in  = '0;
                  rsp_res_in   = 1'b0;
                  rsp_slot_in  = '0;
                  rsp_value_in = '0;
                  rsp_drop_in  = '0;
                  rsp_spur_in  = 1'b1;
               end else begin
                  // head entry is read this cycle
                  state_in = acs_pkg::ST_POP;
               end
            end
         end
         acs_pkg::ST_SCAN: begin
            // one slot per cycle, in slot order
            if (expire) begin
               cd_in[slot_ff] = cur_p;
               if (full_ff) begin
                  if (acc_drop_ff != '1) acc_drop_in = acc_drop_ff + acs_pkg::DROP_W'(1);
               end else begin
                  mem_we  = 1'b1;
                  tail_in = tail_nx;
                  full_in = (tail_nx == head_ff);
                  if (head_ff == tail_ff) begin
                     acc_start_in = 1'b1;
                     acc_chan_in  = channel_of(chan_map_ff, slot_ff);
                  end
               end
            end else begin
               cd_in[slot_ff] = dec;
            end
            if (last_slot) begin
               state_in     = acs_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_start_in = acc_start_in;
               rsp_chan_in  = acc_chan_in;
               rsp_res_in   = 1'b0;
               rsp_slot_in  = '0;
               rsp_value_in = '0;
               rsp_drop_in  = acc_drop_in;
               rsp_spur_in  = 1'b0;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
         acs_pkg::ST_POP: begin
            // rd_data_ff holds the popped slot; fetch the new head
            slot_in = rd_data_ff;
            head_in = head_nx;
            full_in = 1'b0;
            rd_addr = head_nx;
            if (head_nx != tail_ff) begin
               state_in = acs_pkg::ST_NEXT;
            end else begin
               state_in     = acs_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_start_in = 1'b0;
               rsp_chan_in  = '0;
               rsp_res_in   = 1'b1;
               rsp_slot_in  = rd_data_ff;
               rsp_value_in = sample_ff;
               rsp_drop_in  = '0;
               rsp_spur_in  = 1'b0;
            end
         end
         acs_pkg::ST_NEXT: begin
            state_in     = acs_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_start_in = 1'b1;
            rsp_chan_in  = channel_of(chan_map_ff, rd_data_ff);
            rsp_res_in   = 1'b1;
            rsp_slot_in  = slot_ff;
            rsp_value_in = sample_ff;
            rsp_drop_in  = '0;
            rsp_spur_in  = 1'b0;
         end
         default: begin
            state_in = acs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         chan_map_ff  <= '0;
         per_map_ff   <= '0;
         for (int i = 0; i < NS; i++) cd_ff[i] <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         state_ff     <= acs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         chan_map_ff  <= chan_map_in;
         per_map_ff   <= per_map_in;
         cd_ff        <= cd_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      acc_start_ff <= acc_start_in;
      acc_chan_ff  <= acc_chan_in;
      acc_drop_ff  <= acc_drop_in;
      sample_ff    <= sample_in;
      rsp_start_ff <= rsp_start_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_spur_ff  <= rsp_spur_in;
   end

   // Request queue memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= slot_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_valid      = rsp_start_ff;
   assign rsp_start_channel    = rsp_chan_ff;
   assign rsp_result_valid     = rsp_res_ff;
   assign rsp_result_slot      = rsp_slot_ff;
   assign rsp_result_value     = rsp_value_ff;
   assign rsp_dropped_requests = rsp_drop_ff;
   assign rsp_spurious_done    = rsp_spur_ff;

endmodule

// ===== hdl/adc_conversion_sequencer.sv =====
// Top level of the ADC conversion sequencer.
//
// Input channel (req_*): one transfer is a timer tick (req_func = 0) or a
// conversion-finished event (req_func = 1) carrying req_sample_value.
// Result channel (rsp_*): exactly one result per input transfer, in order,
// giving the conversion to start, the finished measurement, the requests
// dropped on a full queue and the spurious-completion flag.
// Configuration (csr_*): a write lands at the edge where csr_write_en is high;
// index 0 is the slot count, 1 the channel map, 2 the period map.
// A two-entry command queue sits between the front end and the sequencer, and
// the result sits in an output register.
// With the result register free, a tick is taken from the command queue,
// then the N enabled slots are walked one slot per cycle through the
// countdown and queue write before rsp_valid is set; a completion passes
// ST_POP, and also ST_NEXT when the next head is read from the request
// queue memory; a spurious completion or a tick with no slot enabled is
// answered from idle. A new command is taken only in idle.
// While a result waits for rsp_ready the sequencer holds; input transfers
// fill the command queue, then req_ready drops.
// Reset is synchronous: queues empty, countdowns, configuration, state and rsp_valid cleared.
module adc_conversion_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [acs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [acs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [acs_pkg::SAMPLE_W-1:0]      req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_start_valid,
   output logic [acs_pkg::CHAN_W-1:0]        rsp_start_channel,
   output logic                              rsp_result_valid,
   output logic [acs_pkg::SLOT_W-1:0]        rsp_result_slot,
   output logic [acs_pkg::SAMPLE_W-1:0]      rsp_result_value,
   output logic [acs_pkg::DROP_W-1:0]        rsp_dropped_requests,
   output logic                              rsp_spurious_done
);

   logic                cmd_valid;
   logic                cmd_pop;
   acs_pkg::cmd_type    cmd_data;

   acs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_sample_value (req_sample_value),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_data         (cmd_data)
   );

   acs_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .cmd_valid            (cmd_valid),
      .cmd_pop              (cmd_pop),
      .cmd_data             (cmd_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_start_valid      (rsp_start_valid),
      .rsp_start_channel    (rsp_start_channel),
      .rsp_result_valid     (rsp_result_valid),
      .rsp_result_slot      (rsp_result_slot),
      .rsp_result_value     (rsp_result_value),
      .rsp_dropped_requests (rsp_dropped_requests),
      .rsp_spurious_done    (rsp_spurious_done)
   );

`ifndef SYNTH
   // sequencer only takes a command that the front end holds
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // a spurious completion changes nothing else
   a_spurious_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spurious_done |->
         !rsp_result_valid && !rsp_start_valid && (rsp_dropped_requests == '0))
      else $error("spurious completion with other activity");

   // drops only come from ticks, which deliver no measurement
   a_drop_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dropped_requests != '0) |-> !rsp_result_valid)
      else $error("drop count on a completion");

   // no conversion start means a zero channel
   a_idle_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_start_valid |-> (rsp_start_channel == '0))
      else $error("channel given without a start");
`endif

endmodule
